// File: src/sorted_priority_queue_unit_defines.svh
// Assertion macros used by the sorted priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_DEFINES_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at each rising edge outside reset.
`define SPQ_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/spq_pkg.sv
// Types and constants shared by the sorted priority queue modules.
package spq_pkg;

  localparam int DEPTH         = 16;
  localparam int PAYLOAD_WIDTH = 32;
  localparam int KEY_W         = 16;
  localparam int CNT_W         = $clog2(DEPTH + 1);
  localparam int ADDR_W        = $clog2(DEPTH);

  // Operation codes of the cmd field.
  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_REMOVE = 1'b1;

  // One stored entry: key above payload.
  typedef struct packed {
    logic signed [KEY_W-1:0]  key;
    logic [PAYLOAD_WIDTH-1:0] payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Outcome of the shared key comparator.
  typedef struct packed {
    logic ge;
    logic eq;
  } cmp_res_t;

endpackage

// File: src/spq_ram.sv
// Generic single write port, single read port RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: src/spq_cmp_unit.sv
// Shared signed key comparator used by both the insert and the remove walk.
module spq_cmp_unit (
  input  logic signed [spq_pkg::KEY_W-1:0] a_key,
  input  logic signed [spq_pkg::KEY_W-1:0] b_key,
  output spq_pkg::cmp_res_t                res
);

  import spq_pkg::*;

  // One signed magnitude compare and one equality test.
  always_comb begin
    res.ge = (a_key >= b_key);
    res.eq = (a_key == b_key);
  end

endmodule

// File: src/sorted_priority_queue_unit.sv
// Sorted priority queue: one command at a time, entries walked through a RAM.
// An insert walks from the tail past every lower key; a remove walks over all held entries.
// An insert into a full queue is refused without a walk.
// One word in flight, so the next word is taken at the earliest while its result is shown.
// Reset empties the queue; RAM contents are left as they are and never read stale.
// Results are shown for one cycle on out_valid; the receiver cannot stall them.
`include "sorted_priority_queue_unit_defines.svh"

module sorted_priority_queue_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_cmd,
  input  logic signed [15:0]                  in_key,
  input  logic [31:0]                         in_payload,
  output logic                                out_valid,
  output logic signed [15:0]                  out_head_key,
  output logic [31:0]                         out_head_payload,
  output logic [4:0]                          out_occupancy,
  output logic                                out_is_empty,
  output logic                                out_insert_refused,
  output logic [4:0]                          out_removed_count
);

  import spq_pkg::*;

  // Sequencer state codes.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RD   = 3'd1;
  localparam logic [2:0] ST_CMP  = 3'd2;
  localparam logic [2:0] ST_HEAD = 3'd3;
  localparam logic [2:0] ST_HDAT = 3'd4;

  logic [2:0]               state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [CNT_W-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]         wr_r, wr_nxt;
  logic                     cmd_r, cmd_nxt;
  logic signed [KEY_W-1:0]  key_r, key_nxt;
  logic [PAYLOAD_WIDTH-1:0] payload_r, payload_nxt;
  logic                     refused_r, refused_nxt;
  logic [CNT_W-1:0]         removed_r, removed_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [31:0]              out_pl_r, out_pl_nxt;
  logic                     out_empty_r, out_empty_nxt;
  logic [CNT_W-1:0]         out_occ_r, out_occ_nxt;
  logic                     out_ref_r, out_ref_nxt;
  logic [CNT_W-1:0]         out_rem_r, out_rem_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  entry_t            ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t            rd_entry;
  entry_t            new_entry;
  cmp_res_t          cmp;

  assign rd_entry          = entry_t'(ram_rdata);
  assign new_entry.key     = key_r;
  assign new_entry.payload = payload_r;

  // Entry store.
  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared comparator: stored key against the command key.
  spq_cmp_unit u_cmp (
    .a_key (rd_entry.key),
    .b_key (key_r),
    .res   (cmp)
  );

  // Sequencer: insert walks down from the tail, remove walks up from the head.
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    wr_nxt        = wr_r;
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    payload_nxt   = payload_r;
    refused_nxt   = refused_r;
    removed_nxt   = removed_r;
    out_valid_nxt = 1'b0;
    out_key_nxt   = out_key_r;
    out_pl_nxt    = out_pl_r;
    out_empty_nxt = out_empty_r;
    out_occ_nxt   = out_occ_r;
    out_ref_nxt   = out_ref_r;
    out_rem_nxt   = out_rem_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = new_entry;
    ram_raddr     = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd_nxt     = in_cmd;
          key_nxt     = in_key;
          payload_nxt = PAYLOAD_WIDTH'(in_payload);
          refused_nxt = 1'b0;
          removed_nxt = '0;
          wr_nxt      = '0;
          if (in_cmd == CMD_INSERT) begin
            if (count_r == CNT_W'(DEPTH)) begin
              refused_nxt = 1'b1;
              state_nxt   = ST_HEAD;
            end else begin
              idx_nxt   = count_r;
              state_nxt = ST_RD;
            end
          end else begin
            idx_nxt   = '0;
            state_nxt = ST_RD;
          end
        end
      end
      ST_RD: begin
        if (cmd_r == CMD_INSERT) begin
          if (idx_r == '0) begin
            // Every entry was lower: the new word becomes the head.
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = new_entry;
            count_nxt = count_r + CNT_W'(1);
            state_nxt = ST_HEAD;
          end else begin
            ram_raddr = ADDR_W'(idx_r - CNT_W'(1));
            state_nxt = ST_CMP;
          end
        end else begin
          if (idx_r == count_r) begin
            count_nxt   = wr_r;
            removed_nxt = count_r - wr_r;
            state_nxt   = ST_HEAD;
          end else begin
            ram_raddr = idx_r[ADDR_W-1:0];
            state_nxt = ST_CMP;
          end
        end
      end
      ST_CMP: begin
        ram_we = 1'b1;
        if (cmd_r == CMD_INSERT) begin
          ram_waddr = idx_r[ADDR_W-1:0];
          if (cmp.ge) begin
            // Equal or higher key stays ahead: place the new word behind it.
            ram_wdata = new_entry;
            count_nxt = count_r + CNT_W'(1);
            state_nxt = ST_HEAD;
          end else begin
            ram_wdata = rd_entry;
            idx_nxt   = idx_r - CNT_W'(1);
            state_nxt = ST_RD;
          end
        end else begin
          // Keep non-matching entries, closing up over the deleted ones.
          ram_we    = !cmp.eq;
          ram_waddr = wr_r[ADDR_W-1:0];
          ram_wdata = rd_entry;
          if (!cmp.eq) begin
            wr_nxt = wr_r + CNT_W'(1);
          end
          idx_nxt   = idx_r + CNT_W'(1);
          state_nxt = ST_RD;
        end
      end
      ST_HEAD: begin
        out_occ_nxt = count_r;
        out_ref_nxt = refused_r;
        out_rem_nxt = removed_r;
        if (count_r == '0) begin
          out_key_nxt   = '0;
          out_pl_nxt    = '0;
          out_empty_nxt = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else begin
          ram_raddr = '0;
          state_nxt = ST_HDAT;
        end
      end
      ST_HDAT: begin
        out_key_nxt   = rd_entry.key;
        out_pl_nxt    = 32'(rd_entry.payload);
        out_empty_nxt = 1'b0;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result words.
  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    wr_r        <= wr_nxt;
    cmd_r       <= cmd_nxt;
    key_r       <= key_nxt;
    payload_r   <= payload_nxt;
    refused_r   <= refused_nxt;
    removed_r   <= removed_nxt;
    out_key_r   <= out_key_nxt;
    out_pl_r    <= out_pl_nxt;
    out_empty_r <= out_empty_nxt;
    out_occ_r   <= out_occ_nxt;
    out_ref_r   <= out_ref_nxt;
    out_rem_r   <= out_rem_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_head_key       = out_key_r;
  assign out_head_payload   = out_pl_r;
  assign out_occupancy      = 5'(out_occ_r);
  assign out_is_empty       = out_empty_r;
  assign out_insert_refused = out_ref_r;
  assign out_removed_count  = 5'(out_rem_r);

  // Checks on the sequencer and the result word.
  `SPQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy,
    "accepted command did not make the block busy")
  `SPQ_ASSERT_IMP(a_strobe_idle, clk, rst_n, out_valid, !busy,
    "result strobe while the sequencer is still working")
  `SPQ_ASSERT_IMP(a_count_range, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH),
    "entry count beyond the queue depth")
  `SPQ_ASSERT_IMP(a_refused_full, clk, rst_n, out_valid && out_insert_refused,
    (out_removed_count == 5'd0) && (out_occupancy == 5'(DEPTH)),
    "refused insert reported without a full queue")
  `SPQ_ASSERT_IMP(a_empty_head, clk, rst_n, out_valid && out_is_empty,
    (out_occupancy == 5'd0) && (out_head_key == 16'sd0) && (out_head_payload == 32'd0),
    "empty queue reported with a head word or entries")

endmodule

// File: tb/sorted_priority_queue_unit_tb.sv
// Self-checking testbench for the sorted priority queue unit: random and directed words.
module sorted_priority_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  localparam int RANDOM_WORDS   = 1630;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * DEPTH + 8;

  // One command word as it is offered to the block.
  typedef struct {
    logic               cmd;
    logic signed [15:0] key;
    logic [31:0]        payload;
  } word_t;

  // What the block should report after one word.
  typedef struct {
    logic signed [15:0] head_key;
    logic [31:0]        head_payload;
    logic [4:0]         occupancy;
    logic               is_empty;
    logic               insert_refused;
    logic [4:0]         removed_count;
  } head_report_t;

  logic clk;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_cmd = CMD_INSERT;
  logic signed [15:0] in_key = '0;
  logic [31:0] in_payload = '0;
  logic out_valid;
  logic signed [15:0] out_head_key;
  logic [31:0] out_head_payload;
  logic [4:0] out_occupancy;
  logic out_is_empty;
  logic out_insert_refused;
  logic [4:0] out_removed_count;

  word_t        pending_words[$];
  head_report_t awaited_reports[$];
  entry_t       held_entries[DEPTH];
  int           held_count = 0;
  int           mismatch_count = 0;
  int           idle_cycles = 0;

  sorted_priority_queue_unit dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_cmd             (in_cmd),
    .in_key             (in_key),
    .in_payload         (in_payload),
    .out_valid          (out_valid),
    .out_head_key       (out_head_key),
    .out_head_payload   (out_head_payload),
    .out_occupancy      (out_occupancy),
    .out_is_empty       (out_is_empty),
    .out_insert_refused (out_insert_refused),
    .out_removed_count  (out_removed_count)
  );

  // Clock: 8 ns period.
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Apply one accepted word to the shadow queue and record the report it should give.
  function automatic void apply_to_shadow(logic cmd, logic signed [15:0] key,
                                          logic [31:0] payload);
    head_report_t rep;
    int pos;
    int kept;
    rep.insert_refused = 1'b0;
    rep.removed_count  = '0;
    if (cmd == CMD_INSERT) begin
      if (held_count >= DEPTH) begin
        rep.insert_refused = 1'b1;
      end else begin
        // Equal keys stay in arrival order, so skip every entry with key >= new key.
        pos = 0;
        while (pos < held_count && held_entries[pos].key >= key) pos++;
        for (int i = held_count; i > pos; i--) held_entries[i] = held_entries[i-1];
        held_entries[pos].key     = key;
        held_entries[pos].payload = payload;
        held_count++;
      end
    end else begin
      // Close up over every matching entry.
      kept = 0;
      for (int i = 0; i < held_count; i++) begin
        if (held_entries[i].key != key) begin
          held_entries[kept] = held_entries[i];
          kept++;
        end
      end
      rep.removed_count = 5'(held_count - kept);
      held_count = kept;
    end
    rep.occupancy = 5'(held_count);
    rep.is_empty  = (held_count == 0);
    if (held_count == 0) begin
      rep.head_key     = '0;
      rep.head_payload = '0;
    end else begin
      rep.head_key     = held_entries[0].key;
      rep.head_payload = held_entries[0].payload;
    end
    awaited_reports.push_back(rep);
  endfunction

  // Mostly short gaps, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 45);
  endfunction

  // Word driver: holds start until the block takes the word, then waits out a gap.
  always @(posedge clk) begin : word_driver
    logic  go;
    word_t w;
    int    gap_left;
    int    quiet_left;
    if (!rst_n) begin
      start      <= 1'b0;
      in_cmd     <= CMD_INSERT;
      in_key     <= '0;
      in_payload <= '0;
      gap_left   = 0;
      quiet_left = 0;
    end else begin
      go = start;
      if (start && !busy) begin
        apply_to_shadow(in_cmd, in_key, in_payload);
        go = 1'b0;
        // Now and then run a stretch back to back.
        if (quiet_left > 0) begin
          quiet_left--;
          gap_left = 0;
        end else if ($urandom_range(0, 99) < 3) begin
          quiet_left = $urandom_range(20, 60);
          gap_left   = 0;
        end else begin
          gap_left = pick_gap();
        end
      end
      if (!go) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_cmd     <= w.cmd;
          in_key     <= w.key;
          in_payload <= w.payload;
          go = 1'b1;
        end
      end
      start <= go;
    end
  end

  // Result monitor: each strobe is checked against the oldest awaited report.
  always @(posedge clk) begin : report_monitor
    head_report_t exp_rep;
    if (rst_n && out_valid) begin
      if (awaited_reports.size() == 0) begin
        $error("result word with no command outstanding");
        mismatch_count++;
      end else begin
        exp_rep = awaited_reports.pop_front();
        if (out_head_key !== exp_rep.head_key) begin
          $error("head_key: expected %0d, got %0d", exp_rep.head_key, out_head_key);
          mismatch_count++;
        end
        if (out_head_payload !== exp_rep.head_payload) begin
          $error("head_payload: expected %h, got %h", exp_rep.head_payload, out_head_payload);
          mismatch_count++;
        end
        if (out_occupancy !== exp_rep.occupancy) begin
          $error("occupancy: expected %0d, got %0d", exp_rep.occupancy, out_occupancy);
          mismatch_count++;
        end
        if (out_is_empty !== exp_rep.is_empty) begin
          $error("is_empty: expected %0b, got %0b", exp_rep.is_empty, out_is_empty);
          mismatch_count++;
        end
        if (out_insert_refused !== exp_rep.insert_refused) begin
          $error("insert_refused: expected %0b, got %0b",
                 exp_rep.insert_refused, out_insert_refused);
          mismatch_count++;
        end
        if (out_removed_count !== exp_rep.removed_count) begin
          $error("removed_count: expected %0d, got %0d",
                 exp_rep.removed_count, out_removed_count);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  function automatic void queue_word(logic cmd, logic signed [15:0] key, logic [31:0] payload);
    word_t w;
    w.cmd     = cmd;
    w.key     = key;
    w.payload = payload;
    pending_words.push_back(w);
  endfunction

  // Extremes and small values turn up often; otherwise any 16-bit key.
  function automatic logic signed [15:0] random_key();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Stimulus and end of run.
  initial begin
    logic signed [15:0] key_pool[4];
    logic signed [15:0] recent_keys[$];
    int pool_size;
    int insert_pct;
    logic signed [15:0] k;

    // Directed part: empty queue, extremes, equal keys, full queue, runs of matches.
    queue_word(CMD_REMOVE, 16'h0000, 32'hDEADBEEF);
    queue_word(CMD_INSERT, 16'h7FFF, 32'hFFFFFFFF);
    queue_word(CMD_INSERT, 16'h8000, 32'h00000000);
    queue_word(CMD_INSERT, 16'h7FFF, 32'h12345678);
    queue_word(CMD_REMOVE, 16'h7FFF, 32'h00000000);
    queue_word(CMD_REMOVE, 16'h0005, 32'hFFFFFFFF);
    for (int i = 0; i < DEPTH - 1; i++)
      queue_word(CMD_INSERT, (i % 4 == 3) ? 16'hFFFF : 16'h0007, {16'hA5A5, 16'(i)});
    queue_word(CMD_INSERT, 16'h7FFF, 32'h5A5A5A5A);
    queue_word(CMD_REMOVE, 16'h0007, 32'h0F0F0F0F);
    queue_word(CMD_REMOVE, 16'h8000, 32'hF0F0F0F0);

    // Random part in phases that fill, drain or churn the queue.
    pool_size  = 4;
    insert_pct = 55;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: insert_pct = 85;
          1: insert_pct = 25;
          default: insert_pct = 55;
        endcase
        // A narrow key pool gives long runs of equal keys.
        pool_size = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 4) : 0;
        for (int j = 0; j < 4; j++) key_pool[j] = random_key();
      end
      if ($urandom_range(0, 99) < insert_pct) begin
        k = (pool_size > 0) ? key_pool[$urandom_range(0, pool_size - 1)] : random_key();
        recent_keys.push_back(k);
        if (recent_keys.size() > DEPTH) void'(recent_keys.pop_front());
        queue_word(CMD_INSERT, k, $urandom());
      end else begin
        if (recent_keys.size() > 0 && $urandom_range(0, 99) < 80)
          k = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        else
          k = (pool_size > 0) ? key_pool[$urandom_range(0, pool_size - 1)] : random_key();
        queue_word(CMD_REMOVE, k, $urandom());
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (!(pending_words.size() == 0 && !start && awaited_reports.size() == 0)
           && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);

    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      // Let any stray result strobe show itself before the verdict.
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (mismatch_count == 0 && awaited_reports.size() == 0) begin
        $display("DONE: 0 errors");
      end else begin
        $display("DONE: errors detected");
      end
      $finish;
    end
  end

endmodule
